### rtl/core/sorted_timer_queue_assert.svh
// Assertion macros for the sorted timer queue.
// Used at the end of the top level; no other dependencies.
`ifndef SORTED_TIMER_QUEUE_ASSERT_SVH
`define SORTED_TIMER_QUEUE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication under reset
`define STQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted_timer_queue: same-cycle check failed");
// Next-cycle implication under reset
`define STQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted_timer_queue: next-cycle check failed");
`else
`define STQ_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define STQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/stq_pkg.sv
// Shared types and constants of the sorted timer queue.
// No dependencies; used by the cell, the controller and the top level.
package stq_pkg;

  localparam int CAPACITY = 32;
  localparam int ID_COUNT = 256;
  localparam int ID_W     = 8;
  localparam int TIME_W   = 48;
  localparam int IVL_W    = 32;
  localparam int PEND_W   = 6;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Input action codes
  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_NONE   = 2'd3
  } stq_action_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_ARMED     = 2'd2,
    ST_NOT_ARMED = 2'd3
  } stq_status_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [ID_W-1:0]   timer_id;
    logic [IVL_W-1:0]  interval_ms;
    logic [TIME_W-1:0] now_ms;
  } stq_in_t;

  typedef struct packed {
    logic              fired;
    logic [ID_W-1:0]   fired_id;
    logic [1:0]        status;
    logic [PEND_W-1:0] pending;
    logic              last;
  } stq_out_t;

  // One queue slot
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] deadline;
    logic [ID_W-1:0]   owner;
  } stq_entry_t;

  localparam stq_entry_t ENTRY_NONE = '0;

  // Operation broadcast to every cell
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_POP
  } stq_cell_op_t;

  typedef struct packed {
    stq_cell_op_t      op;
    logic [TIME_W-1:0] key;
    logic [ID_W-1:0]   id;
  } stq_cell_cmd_t;

  // Chain status seen by the controller
  typedef struct packed {
    logic            armed;
    logic            head_due;
    logic            next_due;
    logic [ID_W-1:0] head_id;
  } stq_chain_t;

endpackage

### rtl/core/stq_cell.sv
// One slot of the sorted chain: holds a deadline and owner, shifts with neighbors.
// Depends on stq_pkg.
module stq_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  stq_pkg::stq_cell_cmd_t cmd,
  input  stq_pkg::stq_entry_t    left_entry,
  input  logic                   left_move,
  input  logic                   left_found,
  input  stq_pkg::stq_entry_t    right_entry,
  output stq_pkg::stq_entry_t    entry,
  output logic                   due,
  output logic                   move,
  output logic                   found
);

  logic                           valid_r, valid_nxt;
  logic [stq_pkg::TIME_W-1:0]     deadline_r, deadline_nxt;
  logic [stq_pkg::ID_W-1:0]       owner_r, owner_nxt;
  stq_pkg::stq_entry_t            ent_nxt;

  assign entry = '{valid: valid_r, deadline: deadline_r, owner: owner_r};

  // Compare against the broadcast key and id
  assign due   = valid_r && (deadline_r <= cmd.key);
  assign move  = !due;
  assign found = left_found || (valid_r && (owner_r == cmd.id));

  // Pick the next slot content
  always_comb begin
    ent_nxt = entry;
    case (cmd.op)
      stq_pkg::CELL_INSERT: begin
        if (move) begin
          if (left_move) begin
            ent_nxt = left_entry;
          end else begin
            ent_nxt = '{valid: 1'b1, deadline: cmd.key, owner: cmd.id};
          end
        end
      end
      stq_pkg::CELL_REMOVE: begin
        if (found) begin
          ent_nxt = right_entry;
        end
      end
      stq_pkg::CELL_POP: begin
        ent_nxt = right_entry;
      end
      default: begin
        ent_nxt = entry;
      end
    endcase
  end

  assign valid_nxt    = ent_nxt.valid;
  assign deadline_nxt = ent_nxt.deadline;
  assign owner_nxt    = ent_nxt.owner;

  // Hold slot; only the valid bit is cleared at reset
  always_ff @(posedge clk) begin
    deadline_r <= deadline_nxt;
    owner_r    <= owner_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

### rtl/core/stq_ctrl.sv
// Sequencer of the sorted timer queue: takes input beats, drives the cell chain,
// keeps time and count, and holds the result beat. Depends on stq_pkg.
module stq_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  stq_pkg::stq_in_t       in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output stq_pkg::stq_out_t      out_data,
  input  stq_pkg::stq_chain_t    chain,
  output stq_pkg::stq_cell_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                      state_r, state_nxt;
  logic [1:0]                  act_r, act_nxt;
  logic [stq_pkg::ID_W-1:0]    id_r, id_nxt;
  logic [stq_pkg::TIME_W-1:0]  dl_r, dl_nxt;
  logic [stq_pkg::TIME_W-1:0]  time_r, time_nxt;
  logic [stq_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic                        out_valid_r, out_valid_nxt;
  stq_pkg::stq_out_t           out_beat_r, out_beat_nxt;
  logic [stq_pkg::TIME_W:0]    sum;
  logic                        out_free;
  logic                        id_bad;
  logic                        full;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_beat_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Deadline of an add, saturated to the time range
  assign sum    = {1'b0, time_r} + (stq_pkg::TIME_W + 1)'(in_data.interval_ms);
  assign id_bad = 32'(id_r) >= 32'(stq_pkg::ID_COUNT);
  assign full   = (count_r == stq_pkg::CNT_W'(stq_pkg::CAPACITY));

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    id_nxt        = id_r;
    dl_nxt        = dl_r;
    time_nxt      = time_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_beat_nxt  = out_beat_r;
    cmd.op        = stq_pkg::CELL_HOLD;
    cmd.key       = (act_r == stq_pkg::ACT_TICK) ? time_r : dl_r;
    cmd.id        = id_r;

    case (state_r)
      S_IDLE: begin
        // Capture the beat; a tick moves the clock right away
        if (in_valid) begin
          act_nxt   = in_data.action;
          id_nxt    = in_data.timer_id;
          dl_nxt    = sum[stq_pkg::TIME_W] ? '1 : sum[stq_pkg::TIME_W-1:0];
          if (in_data.action == stq_pkg::ACT_TICK) begin
            time_nxt = in_data.now_ms;
          end
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // Act once the result register can take a beat
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_beat_nxt      = '0;
          out_beat_nxt.last = 1'b1;
          state_nxt         = S_IDLE;
          case (act_r)
            stq_pkg::ACT_TICK: begin
              if (chain.head_due) begin
                cmd.op                = stq_pkg::CELL_POP;
                count_nxt             = count_r - stq_pkg::CNT_W'(1);
                out_beat_nxt.fired    = 1'b1;
                out_beat_nxt.fired_id = chain.head_id;
                out_beat_nxt.last     = !chain.next_due;
                if (chain.next_due) begin
                  state_nxt = S_EXEC;
                end
              end
            end
            stq_pkg::ACT_ADD: begin
              if (id_bad) begin
                out_beat_nxt.status = stq_pkg::ST_NOT_ARMED;
              end else if (chain.armed) begin
                out_beat_nxt.status = stq_pkg::ST_ARMED;
              end else if (full) begin
                out_beat_nxt.status = stq_pkg::ST_FULL;
              end else begin
                cmd.op    = stq_pkg::CELL_INSERT;
                count_nxt = count_r + stq_pkg::CNT_W'(1);
              end
            end
            stq_pkg::ACT_REMOVE: begin
              if (id_bad || !chain.armed) begin
                out_beat_nxt.status = stq_pkg::ST_NOT_ARMED;
              end else begin
                cmd.op    = stq_pkg::CELL_REMOVE;
                count_nxt = count_r - stq_pkg::CNT_W'(1);
              end
            end
            default: begin
              out_beat_nxt.status = stq_pkg::ST_OK;
            end
          endcase
          out_beat_nxt.pending = stq_pkg::PEND_W'(count_nxt);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, counters and the result beat
  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    id_r       <= id_nxt;
    dl_r       <= dl_nxt;
    out_beat_r <= out_beat_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      time_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      time_r      <= time_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/core/sorted_timer_queue.sv
// Top level of the sorted timer queue: a chain of slot cells and its sequencer.
// Depends on stq_pkg, stq_cell, stq_ctrl and sorted_timer_queue_assert.svh.
//
//   channel  | ports                            | beat
//   ---------+----------------------------------+--------------------------------
//   input    | in_valid, in_stall, in_data      | action, timer_id, interval, now
//   result   | out_valid, out_stall, out_data   | fired, id, status, pending, last
//
// Add, remove and unused codes take the beat in S_IDLE and act in S_EXEC.
// A tick stays in S_EXEC while more timers are due; the head cell pops one timer
// per cycle while the result is not stalled; the whole chain shifts toward it.
// Reset clears every slot's valid bit, the count and the clock at once.
// While the result beat is stalled the chain holds; one more input beat may be
// taken, and it waits to act until the result register frees.
`include "sorted_timer_queue_assert.svh"
module sorted_timer_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  stq_pkg::stq_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output stq_pkg::stq_out_t  out_data
);

  stq_pkg::stq_cell_cmd_t  cmd;
  stq_pkg::stq_chain_t     chain;
  stq_pkg::stq_entry_t     entry_w [stq_pkg::CAPACITY];
  logic [stq_pkg::CAPACITY-1:0] due_w;
  logic [stq_pkg::CAPACITY-1:0] move_w;
  logic [stq_pkg::CAPACITY-1:0] found_w;
  logic [stq_pkg::CAPACITY-1:0] valid_vec;
  logic [stq_pkg::CAPACITY-1:0] valid_inc;
  logic [stq_pkg::PEND_W-1:0]   occupied;

  // Build the chain; the ends see an empty neighbor
  for (genvar i = 0; i < stq_pkg::CAPACITY; i++) begin : g_cell
    stq_pkg::stq_entry_t left_e;
    stq_pkg::stq_entry_t right_e;
    logic                left_m;
    logic                left_f;

    if (i == 0) begin : g_first
      assign left_e = stq_pkg::ENTRY_NONE;
      assign left_m = 1'b0;
      assign left_f = 1'b0;
    end else begin : g_mid
      assign left_e = entry_w[i-1];
      assign left_m = move_w[i-1];
      assign left_f = found_w[i-1];
    end

    if (i == stq_pkg::CAPACITY - 1) begin : g_end
      assign right_e = stq_pkg::ENTRY_NONE;
    end else begin : g_inner
      assign right_e = entry_w[i+1];
    end

    stq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .left_entry  (left_e),
      .left_move   (left_m),
      .left_found  (left_f),
      .right_entry (right_e),
      .entry       (entry_w[i]),
      .due         (due_w[i]),
      .move        (move_w[i]),
      .found       (found_w[i])
    );

    assign valid_vec[i] = entry_w[i].valid;
  end

  // Summarize the chain for the sequencer
  assign chain.armed    = found_w[stq_pkg::CAPACITY-1];
  assign chain.head_due = due_w[0];
  assign chain.next_due = due_w[1];
  assign chain.head_id  = entry_w[0].owner;

  stq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .chain     (chain),
    .cmd       (cmd)
  );

  // Occupancy views for the checks below
  assign valid_inc = valid_vec + stq_pkg::CAPACITY'(1);
  assign occupied  = stq_pkg::PEND_W'($countones(valid_vec));

  // Occupied slots always form an unbroken run from the head
  `STQ_ASSERT_NOW(a_contiguous, clk, rst_n, 1'b1, (valid_vec & valid_inc) == '0)
  // A held result reports exactly the occupied slots
  `STQ_ASSERT_NOW(a_pending, clk, rst_n, out_valid, out_data.pending == occupied)
  // A taken input beat is executed before the next one is taken
  `STQ_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && !in_stall, in_stall)

endmodule

### tb/sv/tb_sorted_timer_queue.sv
`timescale 1ns / 100ps
// Self-checking testbench of sorted_timer_queue: directed and random add, remove and tick
// beats, with a local mirror of the deadline queue that predicts every result beat.
// Depends on stq_pkg and the sorted_timer_queue RTL.
module tb_sorted_timer_queue;
  import stq_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 64;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  stq_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  stq_out_t out_data;

  sorted_timer_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Mirror of the timer queue
  logic [TIME_W-1:0] mirror_deadline [CAPACITY];
  logic [ID_W-1:0]   mirror_owner [CAPACITY];
  int                mirror_count = 0;
  logic [TIME_W-1:0] mirror_now = '0;
  logic              mirror_armed [ID_COUNT];

  stq_in_t  request_fifo [$];
  stq_out_t predicted_replies [$];
  int       mismatches = 0;

  initial begin
    for (int n = 0; n < ID_COUNT; n++) mirror_armed[n] = 1'b0;
  end

  // Apply one accepted request beat to the mirror and queue the result beats it causes
  task automatic apply_timer_request(input stq_in_t req);
    stq_out_t r;
    logic [TIME_W:0] sum;
    logic [TIME_W-1:0] dl;
    int hits;
    int pos;
    int i;
    r = '0;
    r.last = 1'b1;
    case (req.action)
      ACT_TICK: begin
        mirror_now = req.now_ms;
        hits = 0;
        while (hits < mirror_count && mirror_deadline[hits] <= mirror_now) hits++;
        if (hits == 0) begin
          r.pending = PEND_W'(mirror_count);
          predicted_replies.push_back(r);
        end else begin
          // fire due timers from the head, in queue order
          for (i = 0; i < hits; i++) begin
            r.fired = 1'b1;
            r.fired_id = mirror_owner[i];
            r.status = ST_OK;
            r.pending = PEND_W'(mirror_count - i - 1);
            r.last = (i == hits - 1);
            mirror_armed[mirror_owner[i]] = 1'b0;
            predicted_replies.push_back(r);
          end
          for (i = hits; i < mirror_count; i++) begin
            mirror_deadline[i - hits] = mirror_deadline[i];
            mirror_owner[i - hits] = mirror_owner[i];
          end
          mirror_count -= hits;
        end
      end
      ACT_ADD: begin
        if (mirror_armed[req.timer_id]) begin
          r.status = ST_ARMED;
        end else if (mirror_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // saturate the deadline, insert after every deadline at or below it
          sum = {1'b0, mirror_now} + {{(TIME_W + 1 - IVL_W){1'b0}}, req.interval_ms};
          dl = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
          pos = 0;
          while (pos < mirror_count && mirror_deadline[pos] <= dl) pos++;
          for (i = mirror_count; i > pos; i--) begin
            mirror_deadline[i] = mirror_deadline[i - 1];
            mirror_owner[i] = mirror_owner[i - 1];
          end
          mirror_deadline[pos] = dl;
          mirror_owner[pos] = req.timer_id;
          mirror_count++;
          mirror_armed[req.timer_id] = 1'b1;
          r.status = ST_OK;
        end
        r.pending = PEND_W'(mirror_count);
        predicted_replies.push_back(r);
      end
      ACT_REMOVE: begin
        if (!mirror_armed[req.timer_id]) begin
          r.status = ST_NOT_ARMED;
        end else begin
          // drop the entry and close the gap
          pos = 0;
          for (i = 0; i < mirror_count; i++) begin
            if (mirror_owner[i] != req.timer_id) begin
              mirror_deadline[pos] = mirror_deadline[i];
              mirror_owner[pos] = mirror_owner[i];
              pos++;
            end
          end
          mirror_count = pos;
          mirror_armed[req.timer_id] = 1'b0;
          r.status = ST_OK;
        end
        r.pending = PEND_W'(mirror_count);
        predicted_replies.push_back(r);
      end
      default: begin
        r.pending = PEND_W'(mirror_count);
        predicted_replies.push_back(r);
      end
    endcase
  endtask

  // Compare one result beat with the oldest prediction
  task automatic check_reply(input stq_out_t got);
    stq_out_t want;
    if (predicted_replies.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: fired=%0d id=%0d status=%0d pending=%0d last=%0d",
                 got.fired, got.fired_id, got.status, got.pending, got.last);
    end else begin
      want = predicted_replies.pop_front();
      if (got.fired !== want.fired || got.fired_id !== want.fired_id ||
          got.status !== want.status || got.pending !== want.pending ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: expected fired=%0d id=%0d status=%0d pending=%0d ",
                    "last=%0d, got fired=%0d id=%0d status=%0d pending=%0d last=%0d"},
                   want.fired, want.fired_id, want.status, want.pending, want.last,
                   got.fired, got.fired_id, got.status, got.pending, got.last);
      end
    end
  endtask

  function automatic void queue_req(stq_action_t act, logic [ID_W-1:0] id,
                                    logic [IVL_W-1:0] ivl, logic [TIME_W-1:0] now_val);
    stq_in_t b;
    b.action = act;
    b.timer_id = id;
    b.interval_ms = ivl;
    b.now_ms = now_val;
    request_fifo.push_back(b);
  endfunction

  // Mostly a small id pool so adds collide with armed timers
  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 3) == 0) return ID_W'($urandom_range(0, ID_COUNT - 1));
    return ID_W'($urandom_range(0, 15));
  endfunction

  // Driver: send beats in bursts with random gaps, hold while stalled
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_timer_request(in_data);
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_fifo.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= request_fifo.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: take result beats, stall on a pattern whose mode is picked again at random at intervals
  int stall_phase = 0;
  int stall_mode = 0;
  logic stall_next;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_reply(out_data);
      stall_phase++;
      if (stall_phase % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: stall_next = 1'b0;
        1: stall_next = ($urandom_range(0, 2) == 0);
        2: stall_next = ((stall_phase / 8) % 2 == 1);
        default: stall_next = ($urandom_range(0, 2) != 0);
      endcase
      out_stall <= stall_next;
    end
  end

  // Watchdog: end the run when nothing moves while work is outstanding
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else if (request_fifo.size() > 0 || in_valid || predicted_replies.size() > 0)
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    logic [TIME_W-1:0] gen_ms;
    logic [ID_W-1:0] base;
    int pick;
    int k;
    int fills;
    int directed_len;

    // directed: empty tick, unarmed remove, duplicates, ties, saturation, time going back
    queue_req(ACT_TICK, 8'd0, 32'd0, 48'd0);
    queue_req(ACT_REMOVE, 8'd0, 32'd0, 48'd0);
    queue_req(ACT_ADD, 8'd0, 32'd0, 48'd0);
    queue_req(ACT_ADD, 8'd0, 32'd9, 48'd0);
    queue_req(ACT_ADD, 8'd255, 32'hFFFF_FFFF, 48'd0);
    queue_req(ACT_ADD, 8'd7, 32'd5, 48'd0);
    queue_req(ACT_ADD, 8'd8, 32'd5, 48'd0);
    queue_req(ACT_ADD, 8'd6, 32'd5, 48'd0);
    queue_req(ACT_REMOVE, 8'd8, 32'd0, 48'd0);
    queue_req(ACT_NONE, 8'hFF, 32'hFFFF_FFFF, TIME_MAX);
    queue_req(ACT_TICK, 8'd0, 32'd0, 48'd4);
    queue_req(ACT_TICK, 8'd0, 32'd0, 48'd5);
    queue_req(ACT_TICK, 8'd0, 32'd0, 48'd3);
    queue_req(ACT_TICK, 8'd0, 32'd0, 48'hFFFF_FFFF_0000);
    queue_req(ACT_ADD, 8'd3, 32'hFFFF_FFFF, 48'd0);
    queue_req(ACT_ADD, 8'd4, 32'd0, 48'd0);
    queue_req(ACT_TICK, 8'd0, 32'd0, 48'hFFFF_FFFF_FFFE);
    queue_req(ACT_TICK, 8'd0, 32'd0, TIME_MAX);
    queue_req(ACT_REMOVE, 8'd3, 32'd0, 48'd0);
    queue_req(ACT_ADD, 8'hAA, 32'h5555_5555, 48'h5555_5555_5555);
    queue_req(ACT_ADD, 8'h55, 32'hAAAA_AAAA, 48'hAAAA_AAAA_AAAA);
    queue_req(ACT_TICK, 8'd0, 32'd0, 48'd0);
    queue_req(ACT_TICK, 8'd0, 32'd0, TIME_MAX);
    directed_len = request_fifo.size();

    // random: add bursts, advancing ticks, removes, queue fills and noise
    gen_ms = '0;
    fills = 0;
    while (request_fifo.size() < directed_len + 200) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        k = $urandom_range(1, 6);
        repeat (k)
          queue_req(ACT_ADD, pick_id(),
                    ($urandom_range(0, 9) == 0) ? IVL_W'($urandom)
                                                : IVL_W'($urandom_range(0, 60)),
                    TIME_W'({$urandom, $urandom}));
      end else if (pick < 65) begin
        gen_ms = gen_ms + TIME_W'($urandom_range(0, 40));
        queue_req(ACT_TICK, ID_W'($urandom), IVL_W'($urandom), gen_ms);
      end else if (pick < 80) begin
        queue_req(ACT_REMOVE, pick_id(), IVL_W'($urandom), TIME_W'({$urandom, $urandom}));
      end else if (pick < 84 && fills < 2) begin
        // flush, fill to capacity, hit full and armed, then fire all at once
        fills++;
        queue_req(ACT_TICK, 8'd0, 32'd0, TIME_MAX);
        queue_req(ACT_TICK, 8'd0, 32'd0, 48'd0);
        base = ID_W'($urandom);
        for (k = 0; k <= CAPACITY; k++)
          queue_req(ACT_ADD, base + ID_W'(k * 7), IVL_W'($urandom_range(0, 100)), 48'd0);
        queue_req(ACT_ADD, base, 32'd1, 48'd0);
        queue_req(ACT_REMOVE, base + ID_W'(7), 32'd0, 48'd0);
        queue_req(ACT_ADD, base + ID_W'(CAPACITY * 7), IVL_W'($urandom_range(0, 100)),
                  48'd0);
        gen_ms = 48'd200;
        queue_req(ACT_TICK, 8'd0, 32'd0, gen_ms);
      end else begin
        queue_req(stq_action_t'($urandom_range(0, 3)), ID_W'($urandom), IVL_W'($urandom),
                  TIME_W'({$urandom, $urandom}));
        if (request_fifo[$].action == ACT_TICK) gen_ms = request_fifo[$].now_ms;
      end
    end

    // wait for every beat to go out and every result to come back
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (request_fifo.size() > 0 || in_valid) @(posedge clk);
    while (predicted_replies.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && predicted_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/stq_pkg.sv
rtl/core/stq_cell.sv
rtl/core/stq_ctrl.sv
rtl/core/sorted_timer_queue.sv
tb/sv/tb_sorted_timer_queue.sv
